@@ design/s256_pkg.sv @@
// Shared types, constants and round functions for the SHA-256 stream hash unit.
package s256_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hash_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;

  function automatic word_t ror32(input word_t x, input int unsigned n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t iv_const(input logic [2:0] idx);
    case (idx)
      3'd0: iv_const = 32'h6a09e667;
      3'd1: iv_const = 32'hbb67ae85;
      3'd2: iv_const = 32'h3c6ef372;
      3'd3: iv_const = 32'ha54ff53a;
      3'd4: iv_const = 32'h510e527f;
      3'd5: iv_const = 32'h9b05688c;
      3'd6: iv_const = 32'h1f83d9ab;
      3'd7: iv_const = 32'h5be0cd19;
      default: iv_const = 32'h6a09e667;
    endcase
  endfunction

  function automatic word_t k_const(input logic [5:0] idx);
    case (idx)
      6'd0: k_const = 32'h428a2f98;  6'd1: k_const = 32'h71374491;
      6'd2: k_const = 32'hb5c0fbcf;  6'd3: k_const = 32'he9b5dba5;
      6'd4: k_const = 32'h3956c25b;  6'd5: k_const = 32'h59f111f1;
      6'd6: k_const = 32'h923f82a4;  6'd7: k_const = 32'hab1c5ed5;
      6'd8: k_const = 32'hd807aa98;  6'd9: k_const = 32'h12835b01;
      6'd10: k_const = 32'h243185be; 6'd11: k_const = 32'h550c7dc3;
      6'd12: k_const = 32'h72be5d74; 6'd13: k_const = 32'h80deb1fe;
      6'd14: k_const = 32'h9bdc06a7; 6'd15: k_const = 32'hc19bf174;
      6'd16: k_const = 32'he49b69c1; 6'd17: k_const = 32'hefbe4786;
      6'd18: k_const = 32'h0fc19dc6; 6'd19: k_const = 32'h240ca1cc;
      6'd20: k_const = 32'h2de92c6f; 6'd21: k_const = 32'h4a7484aa;
      6'd22: k_const = 32'h5cb0a9dc; 6'd23: k_const = 32'h76f988da;
      6'd24: k_const = 32'h983e5152; 6'd25: k_const = 32'ha831c66d;
      6'd26: k_const = 32'hb00327c8; 6'd27: k_const = 32'hbf597fc7;
      6'd28: k_const = 32'hc6e00bf3; 6'd29: k_const = 32'hd5a79147;
      6'd30: k_const = 32'h06ca6351; 6'd31: k_const = 32'h14292967;
      6'd32: k_const = 32'h27b70a85; 6'd33: k_const = 32'h2e1b2138;
      6'd34: k_const = 32'h4d2c6dfc; 6'd35: k_const = 32'h53380d13;
      6'd36: k_const = 32'h650a7354; 6'd37: k_const = 32'h766a0abb;
      6'd38: k_const = 32'h81c2c92e; 6'd39: k_const = 32'h92722c85;
      6'd40: k_const = 32'ha2bfe8a1; 6'd41: k_const = 32'ha81a664b;
      6'd42: k_const = 32'hc24b8b70; 6'd43: k_const = 32'hc76c51a3;
      6'd44: k_const = 32'hd192e819; 6'd45: k_const = 32'hd6990624;
      6'd46: k_const = 32'hf40e3585; 6'd47: k_const = 32'h106aa070;
      6'd48: k_const = 32'h19a4c116; 6'd49: k_const = 32'h1e376c08;
      6'd50: k_const = 32'h2748774c; 6'd51: k_const = 32'h34b0bcb5;
      6'd52: k_const = 32'h391c0cb3; 6'd53: k_const = 32'h4ed8aa4a;
      6'd54: k_const = 32'h5b9cca4f; 6'd55: k_const = 32'h682e6ff3;
      6'd56: k_const = 32'h748f82ee; 6'd57: k_const = 32'h78a5636f;
      6'd58: k_const = 32'h84c87814; 6'd59: k_const = 32'h8cc70208;
      6'd60: k_const = 32'h90befffa; 6'd61: k_const = 32'ha4506ceb;
      6'd62: k_const = 32'hbef9a3f7; 6'd63: k_const = 32'hc67178f2;
      default: k_const = 32'h428a2f98;
    endcase
  endfunction

endpackage

@@ design/s256_round.sv @@
// One SHA-256 compression round and one message schedule expansion step.
module s256_round (
  input  s256_pkg::hash_t v_in,     // working variables, index 0 is a
  input  s256_pkg::word_t w0,       // W[i]
  input  s256_pkg::word_t w1,       // W[i+1]
  input  s256_pkg::word_t w9,       // W[i+9]
  input  s256_pkg::word_t w14,      // W[i+14]
  input  s256_pkg::word_t k_in,
  output s256_pkg::hash_t v_out,
  output s256_pkg::word_t w_new     // W[i+16]
);

  s256_pkg::word_t big0, big1, choose, major, t1, t2, sig0, sig1;

  always_comb begin
    big1   = s256_pkg::ror32(v_in[4], 6) ^ s256_pkg::ror32(v_in[4], 11) ^
             s256_pkg::ror32(v_in[4], 25);
    choose = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
    big0   = s256_pkg::ror32(v_in[0], 2) ^ s256_pkg::ror32(v_in[0], 13) ^
             s256_pkg::ror32(v_in[0], 22);
    major  = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
    t1     = v_in[7] + big1 + choose + k_in + w0;
    t2     = big0 + major;

    v_out[7] = v_in[6];
    v_out[6] = v_in[5];
    v_out[5] = v_in[4];
    v_out[4] = v_in[3] + t1;
    v_out[3] = v_in[2];
    v_out[2] = v_in[1];
    v_out[1] = v_in[0];
    v_out[0] = t1 + t2;

    sig0  = s256_pkg::ror32(w1, 7) ^ s256_pkg::ror32(w1, 18) ^ (w1 >> 3);
    sig1  = s256_pkg::ror32(w14, 17) ^ s256_pkg::ror32(w14, 19) ^ (w14 >> 10);
    w_new = sig1 + w9 + sig0 + w0;
  end

endmodule

@@ design/sha256_stream_hash_unit.sv @@
// Top level of the SHA-256 stream hash unit: byte intake, padding, compression, digest output.
//
//  Channel  | Direction | Payload                              | Marker
//  ---------+-----------+--------------------------------------+------------------------------
//  in_      | slave     | tdata[7:0] data_byte                 | tuser has_byte, tlast last
//  out_     | master    | tdata[31:0] digest_word, [34:32] idx | tlast last_word
//
// Flow: a message byte is taken while the unit is idle. Each full 64-byte block then holds
// off the input while the block and chain memories are read in the load phase, 64 rounds
// run on the single round unit and the chain update writes the sums back, with memory
// ports that move one word per cycle. A last transaction adds a byte-per-cycle padding
// sweep that fills out the block (plus one more compression when the length spills into a
// second block) and then eight digest words, each read from chain memory and then loaded.
// Reset: synchronous active-low; afterwards a pass writes the eight initial hash
// values into the chain memory, during which in_tready stays low.
// Stalls: a digest word waiting on out_tready holds only the output sequencer; the
// input is taken again as soon as the last digest word sits in the output register.
module sha256_stream_hash_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] has_byte
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        out_tlast   // last_word
);

  typedef enum logic [2:0] {
    ST_INIT, ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_ADD, ST_OUT_RD, ST_OUT_LD
  } state_t;

  state_t           state_r;
  logic [6:0]       cnt_r;
  logic [5:0]       fill_r;
  logic [60:0]      total_r;
  logic [23:0]      asm_r;        // bytes of the word being assembled
  logic             pad_act_r;    // message closed, padding in progress
  logic             mark_r;       // 0x80 marker already placed
  logic             wrap_r;       // marker landed too late for the length field
  logic             final_r;      // block under compression carries the length

  s256_pkg::hash_t  v_r;
  s256_pkg::word_t  w_r [16];
  s256_pkg::hash_t  v_rnd;
  s256_pkg::word_t  w_new;

  // Message block memory: sixteen big-endian words.
  s256_pkg::word_t  blk_mem [16];
  s256_pkg::word_t  blk_rdata_r;
  // Chaining value memory.
  s256_pkg::word_t  chain_mem [8];
  s256_pkg::word_t  chain_rdata_r;

  logic             in_acc;
  logic             push_en;
  logic [7:0]       push_byte;
  logic [7:0]       pad_byte;
  logic             len_sel;
  logic [63:0]      len_bits;
  logic             blk_we;
  logic             chain_we;
  logic [2:0]       chain_waddr;
  s256_pkg::word_t  chain_wdata;
  logic [2:0]       cnt_lo_m1;

  logic             out_tvalid_r;
  s256_pkg::word_t  out_word_r;
  logic [2:0]       out_idx_r;
  logic             out_last_r;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {5'd0, out_idx_r, out_word_r};
  assign out_tlast  = out_last_r;

  // Padding bytes: the marker, then zeros, then the bit length in big-endian order.
  assign len_bits = {total_r, 3'b000};
  assign len_sel  = mark_r && !wrap_r && (fill_r >= s256_pkg::LEN_START);

  always_comb begin
    if (!mark_r) begin
      pad_byte = s256_pkg::PAD_MARK;
    end else if (len_sel) begin
      pad_byte = 8'(len_bits >> {~fill_r[2:0], 3'b000});
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign push_en   = (in_acc && in_tuser) || (state_r == ST_PAD);
  assign push_byte = (state_r == ST_PAD) ? pad_byte : in_tdata;
  assign blk_we    = push_en && (fill_r[1:0] == 2'b11);

  // Block memory is written only while collecting bytes; its read data is used only in the load phase.
  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[fill_r[5:2]] <= {asm_r, push_byte};
    end
    blk_rdata_r <= blk_mem[cnt_r[3:0]];
  end

  // Chain memory: one write port shared by the init pass, the chain update and the
  // reload of the initial values during digest output.
  assign cnt_lo_m1 = cnt_r[2:0] - 3'd1;

  always_comb begin
    chain_we    = 1'b0;
    chain_waddr = cnt_r[2:0];
    chain_wdata = s256_pkg::iv_const(cnt_r[2:0]);
    case (state_r)
      ST_INIT: begin
        chain_we = 1'b1;
      end
      ST_ADD: begin
        chain_we    = (cnt_r != 7'd0);
        chain_waddr = cnt_lo_m1;
        chain_wdata = chain_rdata_r + v_r[0];
      end
      ST_OUT_LD: begin
        chain_we = 1'b1;
      end
      default: begin
        chain_we = 1'b0;
      end
    endcase
  end

  // Reads and writes in the update phase always hit different entries.
  always_ff @(posedge clk) begin
    if (chain_we) begin
      chain_mem[chain_waddr] <= chain_wdata;
    end
    chain_rdata_r <= chain_mem[cnt_r[2:0]];
  end

  s256_round u_round (
    .v_in  (v_r),
    .w0    (w_r[0]),
    .w1    (w_r[1]),
    .w9    (w_r[9]),
    .w14   (w_r[14]),
    .k_in  (s256_pkg::k_const(cnt_r[5:0])),
    .v_out (v_rnd),
    .w_new (w_new)
  );

  // Working variables and schedule window. Loads shift in at the top so that
  // index 0 ends up holding a and W[0].
  always_ff @(posedge clk) begin
    case (state_r)
      ST_LOAD: begin
        if (cnt_r != 7'd0) begin
          for (int i = 0; i < 15; i++) begin
            w_r[i] <= w_r[i + 1];
          end
          w_r[15] <= blk_rdata_r;
          if (cnt_r <= 7'd8) begin
            v_r <= {chain_rdata_r, v_r[7:1]};
          end
        end
      end
      ST_ROUND: begin
        v_r <= v_rnd;
        for (int i = 0; i < 15; i++) begin
          w_r[i] <= w_r[i + 1];
        end
        w_r[15] <= w_new;
      end
      ST_ADD: begin
        if (cnt_r != 7'd0) begin
          v_r <= {v_r[0], v_r[7:1]};
        end
      end
      default: begin
        v_r <= v_r;
      end
    endcase
  end

  // Sequencer, counters and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      cnt_r        <= '0;
      fill_r       <= '0;
      total_r      <= '0;
      pad_act_r    <= 1'b0;
      mark_r       <= 1'b0;
      wrap_r       <= 1'b0;
      final_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (push_en) begin
        asm_r  <= {asm_r[15:0], push_byte};
        fill_r <= fill_r + 6'd1;
      end
      case (state_r)
        ST_INIT: begin
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r[2:0] == 3'd7) begin
            cnt_r   <= '0;
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            if (in_tuser) begin
              total_r <= total_r + 61'd1;
            end
            if (in_tlast) begin
              pad_act_r <= 1'b1;
            end
            if (in_tuser && (fill_r == 6'd63)) begin
              cnt_r   <= '0;
              state_r <= ST_LOAD;
            end else if (in_tlast) begin
              state_r <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (!mark_r) begin
            mark_r <= 1'b1;
          end
          if (fill_r == 6'd63) begin
            wrap_r  <= 1'b0;
            final_r <= len_sel;
            cnt_r   <= '0;
            state_r <= ST_LOAD;
          end else if (!mark_r) begin
            wrap_r <= (fill_r >= s256_pkg::LEN_START);
          end
        end
        ST_LOAD: begin
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd16) begin
            cnt_r   <= '0;
            state_r <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd63) begin
            cnt_r   <= '0;
            state_r <= ST_ADD;
          end
        end
        ST_ADD: begin
          cnt_r <= cnt_r + 7'd1;
          if (cnt_r == 7'd8) begin
            cnt_r <= '0;
            if (final_r) begin
              state_r <= ST_OUT_RD;
            end else if (pad_act_r) begin
              state_r <= ST_PAD;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        ST_OUT_RD: begin
          if (!out_tvalid_r || out_tready) begin
            state_r <= ST_OUT_LD;
          end
        end
        ST_OUT_LD: begin
          out_tvalid_r <= 1'b1;
          out_word_r   <= chain_rdata_r;
          out_idx_r    <= cnt_r[2:0];
          out_last_r   <= (cnt_r[2:0] == 3'd7);
          cnt_r        <= cnt_r + 7'd1;
          if (cnt_r[2:0] == 3'd7) begin
            cnt_r     <= '0;
            total_r   <= '0;
            pad_act_r <= 1'b0;
            mark_r    <= 1'b0;
            final_r   <= 1'b0;
            state_r   <= ST_IDLE;
          end else begin
            state_r <= ST_OUT_RD;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // A digest word only ever appears from the output load step.
  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_OUT_LD))
    else $error("output valid raised outside the digest load step");

  // The output register is always free when a digest word is loaded.
  a_out_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT_LD) |-> !out_tvalid_r)
    else $error("digest word would overwrite a pending transaction");

  // Digest output starts only after the padded message filled whole blocks.
  a_fill_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT_RD) |-> (fill_r == 6'd0) && mark_r && !wrap_r)
    else $error("digest output with a partial block pending");

  // No byte is written into the block memory while it is being read for compression.
  a_no_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD || state_r == ST_ROUND || state_r == ST_ADD) |-> !push_en)
    else $error("block memory written during compression");

  // The chain update always follows the last round.
  a_round_to_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && cnt_r == 7'd63) |=> (state_r == ST_ADD))
    else $error("round sequence did not end in the chain update");

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the SHA-256 stream hash unit with its own digest predictor.
module tb_top;
  typedef s256_pkg::word_t word_t;

  // Clock, reset and the block's ports. Every input starts at a known value.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] data_byte
  logic        in_tuser = 1'b0;    // [0] has_byte
  logic        in_tlast = 1'b0;    // last
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;          // [31:0] digest_word, [34:32] word_index, [39:35] zero
  logic        out_tlast;          // last_word

  localparam int unsigned RANDOM_ITEMS = 192;
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned MAX_REPORTS = 10;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam int unsigned LEN_SLOT = 56;

  // Digests of the empty message and of "abc", as published for SHA-256.
  localparam logic [255:0] DIGEST_EMPTY =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] DIGEST_ABC =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;
  localparam logic [255:0] NO_DIGEST = '0;

  localparam word_t HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // One digest word as it should leave the block.
  typedef struct packed {
    word_t      digest;
    logic [2:0] idx;
    logic       lastw;
  } digest_entry_t;

  // One row of the directed table. Rows with has_digest set carry the published digest,
  // which replaces the predicted one; every other row relies on the predictor.
  typedef struct packed {
    logic [7:0]   data;
    logic         has;
    logic         fin;
    logic         has_digest;
    logic [255:0] digest;
  } byte_row_t;

  localparam int unsigned DIRECTED_COUNT = 18;
  localparam byte_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // An idle transaction straight after reset must change nothing.
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST},
    // The empty message, closed by a transaction that carries no byte.
    '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY},
    // "abc" with the closing flag riding on the final byte.
    '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h63, 1'b1, 1'b1, 1'b1, DIGEST_ABC},
    // "abc" again with an idle transaction inside and a separate byteless close.
    '{8'h61, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h00, 1'b0, 1'b0, 1'b0, NO_DIGEST},
    '{8'h62, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h63, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h00, 1'b0, 1'b1, 1'b1, DIGEST_ABC},
    // Byte extremes.
    '{8'hff, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'h00, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'hff, 1'b1, 1'b1, 1'b0, NO_DIGEST},
    // A single zero byte.
    '{8'h00, 1'b1, 1'b1, 1'b0, NO_DIGEST},
    // A byte marked as absent must be ignored even when its bits are all ones.
    '{8'h55, 1'b1, 1'b0, 1'b0, NO_DIGEST},
    '{8'hff, 1'b0, 1'b0, 1'b0, NO_DIGEST},
    '{8'haa, 1'b1, 1'b1, 1'b0, NO_DIGEST},
    // A byteless close with nonzero data is still the empty message.
    '{8'h5a, 1'b0, 1'b1, 1'b1, DIGEST_EMPTY}
  };

  // Predictor state: chaining value, block buffer, fill level and message length.
  word_t         chain_q [8];
  logic [7:0]    blk_q [64];
  int unsigned   fill_q;
  logic [60:0]   total_q;

  // Digest words predicted but not yet seen on the output.
  digest_entry_t digest_q [$];
  int unsigned   mismatch_count = 0;

  int unsigned   send_burst = 0;
  int unsigned   items_sent = 0;

  sha256_stream_hash_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic word_t rotr(word_t x, int unsigned n);
    logic [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  // One 64-round compression of blk_q into chain_q.
  function automatic void compress_block();
    word_t sched [64];
    word_t v [8];
    word_t s0, s1, t1, t2, choose, major;
    int i;
    for (i = 0; i < 16; i++) begin
      sched[i] = {blk_q[4*i], blk_q[4*i+1], blk_q[4*i+2], blk_q[4*i+3]};
    end
    for (i = 16; i < 64; i++) begin
      s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
      s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
      sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
    end
    v = chain_q;
    for (i = 0; i < 64; i++) begin
      s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
      choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
      s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
      major = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
      t1 = v[7] + s1 + choose + ROUND_K[i] + sched[i];
      t2 = s0 + major;
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (i = 0; i < 8; i++) begin
      chain_q[i] = chain_q[i] + v[i];
    end
  endfunction

  // Absorbs one accepted transaction. A closing transaction pads the message, runs the
  // final compressions and queues the eight digest words it should produce.
  function automatic void absorb_item(logic [7:0] b, logic has, logic fin, logic has_digest,
                                      logic [255:0] digest);
    logic [63:0]   bit_len;
    digest_entry_t entry;
    int            i;
    if (has) begin
      blk_q[fill_q] = b;
      total_q = total_q + 61'd1;
      fill_q++;
      if (fill_q == 64) begin
        compress_block();
        fill_q = 0;
      end
    end
    if (fin) begin
      bit_len = {total_q, 3'b000};
      blk_q[fill_q] = PAD_BYTE;
      for (i = fill_q + 1; i < 64; i++) begin
        blk_q[i] = 8'h00;
      end
      // No room left for the length field: it spills into an extra block.
      if (fill_q >= LEN_SLOT) begin
        compress_block();
        for (i = 0; i < 64; i++) begin
          blk_q[i] = 8'h00;
        end
      end
      for (i = 0; i < 8; i++) begin
        blk_q[LEN_SLOT + i] = bit_len[63 - 8*i -: 8];
      end
      compress_block();
      for (i = 0; i < 8; i++) begin
        entry.digest = has_digest ? digest[255 - 32*i -: 32] : chain_q[i];
        entry.idx = 3'(i);
        entry.lastw = (i == 7);
        digest_q.push_back(entry);
      end
      chain_q = HASH_INIT;
      fill_q = 0;
      total_q = '0;
    end
  endfunction

  // Drives one input transaction after a random gap, waits for it to be taken and feeds
  // it to the predictor. The valid line is only lowered when a gap follows, so
  // back-to-back transactions keep it high.
  task automatic send_item(logic [7:0] b, logic has, logic fin, logic has_digest,
                           logic [255:0] digest);
    int unsigned gap;
    if (send_burst > 0) begin
      gap = 0;
      send_burst--;
    end else begin
      gap = $urandom_range(0, 6);
      if ($urandom_range(0, 19) == 0) begin
        send_burst = $urandom_range(10, 60);
      end
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tuser <= has;
    in_tlast <= fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    absorb_item(b, has, fin, has_digest, digest);
  endtask

  // Holds the input off until every predicted digest word has come out.
  task automatic drain_digests();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (digest_q.size() != 0);
  endtask

  // Picks a message length: mostly short, often at a padding or block boundary.
  function automatic int unsigned pick_length();
    int unsigned edges [10];
    edges = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom_range(0, 8);
      4, 5, 6: return edges[$urandom_range(0, 9)];
      default: return $urandom_range(9, 70);
    endcase
  endfunction

  // Main stimulus: reset, the directed table, one full drain, then random messages.
  initial begin : stimulus
    int unsigned row;
    int unsigned k;
    int unsigned msg_len;
    int unsigned remaining;
    logic        close_on_byte;
    chain_q = HASH_INIT;
    fill_q = 0;
    total_q = '0;
    for (k = 0; k < 64; k++) begin
      blk_q[k] = 8'h00;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (row = 0; row < DIRECTED_COUNT; row++) begin
      send_item(DIRECTED_ROWS[row].data, DIRECTED_ROWS[row].has, DIRECTED_ROWS[row].fin,
                DIRECTED_ROWS[row].has_digest, DIRECTED_ROWS[row].digest);
    end
    drain_digests();

    // Every message is well formed by construction; idle transactions sprinkled in and
    // byteless closes make up the noise. A message is cut short so that the run stays
    // near its transaction budget.
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        drain_digests();
      end
      remaining = RANDOM_ITEMS - items_sent;
      msg_len = pick_length();
      if (msg_len >= remaining) begin
        msg_len = remaining - 1;
      end
      close_on_byte = (msg_len > 0) && ($urandom_range(0, 2) != 0);
      for (k = 0; k < msg_len; k++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, NO_DIGEST);
          items_sent++;
        end
        send_item(8'($urandom_range(0, 255)), 1'b1, close_on_byte && (k == msg_len - 1),
                  1'b0, NO_DIGEST);
        items_sent++;
      end
      if (!close_on_byte) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, NO_DIGEST);
        items_sent++;
      end
    end

    drain_digests();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && digest_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Output back-pressure: a random stall before each digest transaction, with
  // occasional stretches where the output is always ready.
  initial begin : ready_driver
    int unsigned stall;
    int unsigned ready_burst;
    ready_burst = 0;
    @(posedge clk);
    forever begin
      if (ready_burst > 0) begin
        stall = 0;
        ready_burst--;
      end else begin
        stall = $urandom_range(0, 6);
        if ($urandom_range(0, 11) == 0) begin
          ready_burst = $urandom_range(8, 40);
        end
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Checks each digest transaction against the oldest predicted word.
  always @(posedge clk) begin : digest_check
    digest_entry_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected digest transaction: word %h index %0d last %b",
                   out_tdata[31:0], out_tdata[34:32], out_tlast);
        end
      end else begin
        want = digest_q.pop_front();
        if (out_tdata[31:0] !== want.digest || out_tdata[34:32] !== want.idx ||
            out_tlast !== want.lastw || out_tdata[39:35] !== 5'b00000) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("digest mismatch: expected %h idx %0d last %b, got %h idx %0d last %b",
                     want.digest, want.idx, want.lastw,
                     out_tdata[31:0], out_tdata[34:32], out_tlast);
            $display("  upper bits %b", out_tdata[39:35]);
          end
        end
      end
    end
  end

  // Hard stop, far beyond the slowest legal run (about 210 transactions, each possibly a
  // byteless close with a full padding sweep, a block compression and eight digest words
  // under output stalls), so it only trips on a hang.
  initial begin : watchdog
    #(12 * 400000);
    $display("status: fail");
    $finish;
  end

endmodule

@@ filelist.f @@
design/s256_pkg.sv
design/s256_round.sv
design/sha256_stream_hash_unit.sv
tb/tb_top.sv
